FILE: rtl/cpfm_pkg.sv
// Shared constants, types and helper functions for the copy-on-write page frame manager.
`timescale 1ns / 1ps

package cpfm_pkg;

  // Sizing of the page tables, the frame pool and the process slots.
  localparam int ENTRIES_PER_LEVEL = 16;
  localparam int FRAME_COUNT       = 128;
  localparam int PROCESS_SLOTS     = 8;

  localparam int PAGES     = ENTRIES_PER_LEVEL * ENTRIES_PER_LEVEL;
  localparam int PAGE_W    = $clog2(PAGES);
  localparam int SLOT_W    = $clog2(PROCESS_SLOTS);
  localparam int FRAME_W   = $clog2(FRAME_COUNT);
  localparam int ADDR_W    = SLOT_W + PAGE_W;
  localparam int ENT_DEPTH = PROCESS_SLOTS << PAGE_W;

  // Share counters saturate at the top of their range.
  localparam int               CNT_W     = 4;
  localparam logic [CNT_W-1:0] SHARE_MAX = '1;

  // The free-frame scan looks at one group of frames per cycle.
  localparam int SRCH_GRP = 8;
  localparam int SRCH_W   = (SRCH_GRP > 1) ? $clog2(SRCH_GRP) : 1;
  localparam int NGROUP   = (FRAME_COUNT + SRCH_GRP - 1) / SRCH_GRP;
  localparam int GRP_W    = (NGROUP > 1) ? $clog2(NGROUP) : 1;

  // Field widths of the stream payloads.
  localparam int VPN_W    = 8;
  localparam int PID_W    = 16;
  localparam int OUT_FR_W = 7;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_FAULT  = 2'd2,
    OP_SWITCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FAIL       = 2'd1,
    STAT_SLOTS_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_DISPATCH,
    FS_ENT,
    FS_CNT,
    FS_SRCH,
    FS_FLT_WR2,
    FS_FK_RD,
    FS_FK_ENT,
    FS_FK_WP,
    FS_FK_WC,
    FS_DONE
  } fsm_t;

  typedef struct packed {
    logic               valid;
    logic               writable;
    logic               priv;
    logic [FRAME_W-1:0] pfn;
  } entry_t;

  // Requests from the sequencer to the share-count unit.
  typedef struct packed {
    logic               rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic               wr_en;
    logic [FRAME_W-1:0] wr_addr;
    logic [CNT_W-1:0]   wr_cnt;
    logic               search_start;
  } share_req_t;

  // Answers from the share-count unit.
  typedef struct packed {
    logic [CNT_W-1:0]   rd_cnt;
    logic               search_done;
    logic               search_found;
    logic [FRAME_W-1:0] search_frame;
  } share_rsp_t;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == SHARE_MAX) ? c : c + 1'b1;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == '0) ? c : c - 1'b1;
    return r;
  endfunction

endpackage

FILE: rtl/cpfm_share_unit.sv
// Frame share-count memory with a free-frame bitmap and an iterative lowest-free-frame scan.
`timescale 1ns / 1ps

module cpfm_share_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  cpfm_pkg::share_req_t req,
  output cpfm_pkg::share_rsp_t rsp
);

  localparam int PAD_W = cpfm_pkg::NGROUP * cpfm_pkg::SRCH_GRP;

  // Share counts; an entry is only meaningful while its free bit is clear.
  logic [cpfm_pkg::CNT_W-1:0] cnt_mem [cpfm_pkg::FRAME_COUNT];
  logic [cpfm_pkg::FRAME_COUNT-1:0] free_r;
  logic [cpfm_pkg::CNT_W-1:0] mem_q_r;
  logic free_q_r;

  // Scan state.
  logic                         busy_r, busy_nxt;
  logic [cpfm_pkg::GRP_W-1:0]   grp_r, grp_nxt;
  logic                         done_r, done_nxt;
  logic                         found_r, found_nxt;
  logic [cpfm_pkg::FRAME_W-1:0] frame_r, frame_nxt;

  logic [PAD_W-1:0]              free_pad;
  logic [cpfm_pkg::SRCH_GRP-1:0] grp_bits;
  logic [cpfm_pkg::SRCH_W-1:0]   pri;

  // Count memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      cnt_mem[req.wr_addr] <= req.wr_cnt;
    end
    if (req.rd_en) begin
      mem_q_r  <= cnt_mem[req.rd_addr];
      free_q_r <= free_r[req.rd_addr];
    end
  end

  // Free bitmap: every frame starts free, a write of zero frees it again.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
    end else if (req.wr_en) begin
      free_r[req.wr_addr] <= (req.wr_cnt == '0);
    end
  end

  // Lowest set bit of the group under the scan.
  always_comb begin
    free_pad = PAD_W'(free_r);
    grp_bits = free_pad[grp_r * cpfm_pkg::SRCH_GRP +: cpfm_pkg::SRCH_GRP];
    pri      = '0;
    for (int i = cpfm_pkg::SRCH_GRP - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        pri = cpfm_pkg::SRCH_W'(i);
      end
    end
  end

  // Scan sequencing, one group per cycle.
  always_comb begin
    busy_nxt  = busy_r;
    grp_nxt   = grp_r;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    frame_nxt = frame_r;
    if (req.search_start) begin
      busy_nxt = 1'b1;
      grp_nxt  = '0;
    end else if (busy_r) begin
      if (|grp_bits) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        found_nxt = 1'b1;
        frame_nxt = cpfm_pkg::FRAME_W'(32'(grp_r) * cpfm_pkg::SRCH_GRP + 32'(pri));
      end else if (grp_r == cpfm_pkg::GRP_W'(cpfm_pkg::NGROUP - 1)) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        found_nxt = 1'b0;
      end else begin
        grp_nxt = grp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    grp_r   <= grp_nxt;
    found_r <= found_nxt;
    frame_r <= frame_nxt;
  end

  always_comb begin
    rsp.rd_cnt       = free_q_r ? '0 : mem_q_r;
    rsp.search_done  = done_r;
    rsp.search_found = found_r;
    rsp.search_frame = frame_r;
  end

endmodule

FILE: rtl/cow_page_frame_manager.sv
// Top level: page-table memory, process slots and the command sequencer.
`timescale 1ns / 1ps
// An alloc, and a fault on a shared page, scan for the lowest free frame at 8 frames a cycle;
// a fork copies every table page of the current slot into the new child slot.
// Throughput: one command at a time; a new command is taken while the last result waits.
// The page-table memory has one read port and one write port; a fork visits the pages in turn.
// Reset is synchronous, active low; a clearing pass then writes all 2048 page-table entries,
// and no command is taken during it.

module cow_page_frame_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // vpn[7:0], is_read_only[8], pid[24:9], zero[31:25]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], frame[8:2], zero[15:9]
);

  localparam int SLOTS = cpfm_pkg::PROCESS_SLOTS;

  cpfm_pkg::fsm_t state_r, state_nxt;

  cpfm_pkg::op_t                 op_r, op_nxt;
  logic [cpfm_pkg::VPN_W-1:0]    vpn_r, vpn_nxt;
  logic                          ro_r, ro_nxt;
  logic [cpfm_pkg::PID_W-1:0]    pid_r, pid_nxt;
  cpfm_pkg::entry_t              ent_r, ent_nxt;
  logic [cpfm_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  cpfm_pkg::status_t             status_r, status_nxt;
  logic [cpfm_pkg::OUT_FR_W-1:0] frame_r, frame_nxt;
  logic [cpfm_pkg::ADDR_W-1:0]   clr_r, clr_nxt;
  logic [cpfm_pkg::PAGE_W-1:0]   v_r, v_nxt;
  logic [cpfm_pkg::SLOT_W-1:0]   child_r, child_nxt;
  logic [cpfm_pkg::SLOT_W-1:0]   cur_r, cur_nxt;
  logic [SLOTS-1:0]              used_r, used_nxt;
  logic [cpfm_pkg::PID_W-1:0]    slotpid_r [SLOTS];
  logic [cpfm_pkg::PID_W-1:0]    slotpid_nxt [SLOTS];
  logic                          out_valid_r, out_valid_nxt;
  logic [15:0]                   out_data_r, out_data_nxt;

  // Page-table memory port.
  cpfm_pkg::entry_t            ent_mem [cpfm_pkg::ENT_DEPTH];
  cpfm_pkg::entry_t            ent_q_r;
  logic                        ent_re, ent_we;
  logic [cpfm_pkg::ADDR_W-1:0] ent_ra, ent_wa;
  cpfm_pkg::entry_t            ent_wd;

  cpfm_pkg::share_req_t sreq;
  cpfm_pkg::share_rsp_t srsp;

  logic                        in_xfer;
  logic                        in_range;
  logic [cpfm_pkg::ADDR_W-1:0] cur_addr;
  logic [SLOTS-1:0]            match_v;
  logic                        match_any, free_any;
  logic [cpfm_pkg::SLOT_W-1:0] match_idx, free_idx;
  logic                        fk_last;

  cpfm_share_unit u_share (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .rsp   (srsp)
  );

  // Page-table memory with a registered read.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (ent_re) begin
      ent_q_r <= ent_mem[ent_ra];
    end
  end

  assign in_tready  = (state_r == cpfm_pkg::FS_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_range = 32'(vpn_r) < 32'(cpfm_pkg::PAGES);
  assign cur_addr = {cur_r, cpfm_pkg::PAGE_W'(vpn_r)};
  assign fk_last  = (v_r == cpfm_pkg::PAGE_W'(cpfm_pkg::PAGES - 1));

  // Slot lookup for switch, and the lowest unused slot for fork.
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      match_v[s] = used_r[s] && (cpfm_pkg::SLOT_W'(s) != cur_r) && (slotpid_r[s] == pid_r);
      if (match_v[s]) begin
        match_idx = cpfm_pkg::SLOT_W'(s);
      end
      if (!used_r[s]) begin
        free_idx = cpfm_pkg::SLOT_W'(s);
      end
    end
    match_any = |match_v;
    free_any  = ~&used_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpfm_pkg::FS_CLEAR: begin
        if (clr_r == cpfm_pkg::ADDR_W'(cpfm_pkg::ENT_DEPTH - 1)) begin
          state_nxt = cpfm_pkg::FS_IDLE;
        end
      end
      cpfm_pkg::FS_IDLE: begin
        if (in_xfer) begin
          state_nxt = cpfm_pkg::FS_DISPATCH;
        end
      end
      cpfm_pkg::FS_DISPATCH: begin
        case (op_r)
          cpfm_pkg::OP_ALLOC: state_nxt = in_range ? cpfm_pkg::FS_SRCH : cpfm_pkg::FS_DONE;
          cpfm_pkg::OP_FREE,
          cpfm_pkg::OP_FAULT: state_nxt = in_range ? cpfm_pkg::FS_ENT : cpfm_pkg::FS_DONE;
          default: begin
            state_nxt = (!match_any && free_any) ? cpfm_pkg::FS_FK_RD : cpfm_pkg::FS_DONE;
          end
        endcase
      end
      cpfm_pkg::FS_ENT: begin
        if (op_r == cpfm_pkg::OP_FREE) begin
          state_nxt = ent_q_r.valid ? cpfm_pkg::FS_CNT : cpfm_pkg::FS_DONE;
        end else begin
          state_nxt = (ent_q_r.valid && ent_q_r.priv) ? cpfm_pkg::FS_CNT : cpfm_pkg::FS_DONE;
        end
      end
      cpfm_pkg::FS_CNT: begin
        if (op_r == cpfm_pkg::OP_FAULT && srsp.rd_cnt != cpfm_pkg::CNT_W'(1)) begin
          state_nxt = cpfm_pkg::FS_SRCH;
        end else begin
          state_nxt = cpfm_pkg::FS_DONE;
        end
      end
      cpfm_pkg::FS_SRCH: begin
        if (srsp.search_done) begin
          if (op_r == cpfm_pkg::OP_FAULT && srsp.search_found &&
              srsp.search_frame != ent_r.pfn) begin
            state_nxt = cpfm_pkg::FS_FLT_WR2;
          end else begin
            state_nxt = cpfm_pkg::FS_DONE;
          end
        end
      end
      cpfm_pkg::FS_FLT_WR2: state_nxt = cpfm_pkg::FS_DONE;
      cpfm_pkg::FS_FK_RD:   state_nxt = cpfm_pkg::FS_FK_ENT;
      cpfm_pkg::FS_FK_ENT: begin
        state_nxt = ent_q_r.valid ? cpfm_pkg::FS_FK_WP : cpfm_pkg::FS_FK_WC;
      end
      cpfm_pkg::FS_FK_WP: state_nxt = cpfm_pkg::FS_FK_WC;
      cpfm_pkg::FS_FK_WC: state_nxt = fk_last ? cpfm_pkg::FS_DONE : cpfm_pkg::FS_FK_RD;
      cpfm_pkg::FS_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = cpfm_pkg::FS_IDLE;
        end
      end
      default: state_nxt = cpfm_pkg::FS_IDLE;
    endcase
  end

  // Datapath and memory controls for each state.
  always_comb begin
    op_nxt        = op_r;
    vpn_nxt       = vpn_r;
    ro_nxt        = ro_r;
    pid_nxt       = pid_r;
    ent_nxt       = ent_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    frame_nxt     = frame_r;
    clr_nxt       = clr_r;
    v_nxt         = v_r;
    child_nxt     = child_r;
    cur_nxt       = cur_r;
    used_nxt      = used_r;
    slotpid_nxt   = slotpid_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ent_re        = 1'b0;
    ent_ra        = '0;
    ent_we        = 1'b0;
    ent_wa        = '0;
    ent_wd        = '0;
    sreq          = '0;

    // The result register empties when its transfer completes.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      cpfm_pkg::FS_CLEAR: begin
        ent_we  = 1'b1;
        ent_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      cpfm_pkg::FS_IDLE: begin
        if (in_xfer) begin
          op_nxt  = cpfm_pkg::op_t'(in_tuser);
          vpn_nxt = in_tdata[7:0];
          ro_nxt  = in_tdata[8];
          pid_nxt = in_tdata[24:9];
        end
      end
      cpfm_pkg::FS_DISPATCH: begin
        frame_nxt = '0;
        case (op_r)
          cpfm_pkg::OP_ALLOC: begin
            status_nxt        = cpfm_pkg::STAT_FAIL;
            sreq.search_start = in_range;
          end
          cpfm_pkg::OP_FREE: begin
            status_nxt = cpfm_pkg::STAT_OK;
            ent_re     = in_range;
            ent_ra     = cur_addr;
          end
          cpfm_pkg::OP_FAULT: begin
            status_nxt = cpfm_pkg::STAT_FAIL;
            ent_re     = in_range;
            ent_ra     = cur_addr;
          end
          default: begin
            status_nxt = cpfm_pkg::STAT_OK;
            v_nxt      = '0;
            child_nxt  = free_idx;
            if (match_any) begin
              cur_nxt = match_idx;
            end else if (!free_any) begin
              status_nxt = cpfm_pkg::STAT_SLOTS_FULL;
            end
          end
        endcase
      end
      cpfm_pkg::FS_ENT: begin
        ent_nxt      = ent_q_r;
        sreq.rd_en   = 1'b1;
        sreq.rd_addr = ent_q_r.pfn;
      end
      cpfm_pkg::FS_CNT: begin
        cnt_nxt = srsp.rd_cnt;
        if (op_r == cpfm_pkg::OP_FREE) begin
          // Release one share and unmap the page.
          sreq.wr_en   = 1'b1;
          sreq.wr_addr = ent_r.pfn;
          sreq.wr_cnt  = cpfm_pkg::cnt_dec(srsp.rd_cnt);
          ent_we       = 1'b1;
          ent_wa       = cur_addr;
        end else if (srsp.rd_cnt == cpfm_pkg::CNT_W'(1)) begin
          // Sole owner: make the page writable in place.
          ent_we          = 1'b1;
          ent_wa          = cur_addr;
          ent_wd          = ent_r;
          ent_wd.writable = 1'b1;
          status_nxt      = cpfm_pkg::STAT_OK;
        end else begin
          sreq.search_start = 1'b1;
        end
      end
      cpfm_pkg::FS_SRCH: begin
        if (srsp.search_done && srsp.search_found) begin
          status_nxt = cpfm_pkg::STAT_OK;
          ent_we     = 1'b1;
          ent_wa     = cur_addr;
          if (op_r == cpfm_pkg::OP_ALLOC) begin
            frame_nxt    = cpfm_pkg::OUT_FR_W'(srsp.search_frame);
            sreq.wr_en   = 1'b1;
            sreq.wr_addr = srsp.search_frame;
            sreq.wr_cnt  = cpfm_pkg::CNT_W'(1);
            ent_wd       = '{valid: 1'b1, writable: !ro_r, priv: !ro_r,
                             pfn: srsp.search_frame};
          end else begin
            // Move to the new frame; when it is the old one, the counts cancel out.
            sreq.wr_en   = (srsp.search_frame != ent_r.pfn);
            sreq.wr_addr = srsp.search_frame;
            sreq.wr_cnt  = cpfm_pkg::CNT_W'(1);
            ent_wd       = '{valid: 1'b1, writable: 1'b1, priv: ent_r.priv,
                             pfn: srsp.search_frame};
          end
        end
      end
      cpfm_pkg::FS_FLT_WR2: begin
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = ent_r.pfn;
        sreq.wr_cnt  = cpfm_pkg::cnt_dec(cnt_r);
      end
      cpfm_pkg::FS_FK_RD: begin
        ent_re = 1'b1;
        ent_ra = {cur_r, v_r};
      end
      cpfm_pkg::FS_FK_ENT: begin
        ent_nxt      = ent_q_r;
        sreq.rd_en   = ent_q_r.valid;
        sreq.rd_addr = ent_q_r.pfn;
      end
      cpfm_pkg::FS_FK_WP: begin
        // Parent loses write access and the frame gains a share.
        ent_we          = 1'b1;
        ent_wa          = {cur_r, v_r};
        ent_wd          = ent_r;
        ent_wd.writable = 1'b0;
        sreq.wr_en      = 1'b1;
        sreq.wr_addr    = ent_r.pfn;
        sreq.wr_cnt     = cpfm_pkg::cnt_inc(srsp.rd_cnt);
      end
      cpfm_pkg::FS_FK_WC: begin
        ent_we = 1'b1;
        ent_wa = {child_r, v_r};
        if (ent_r.valid) begin
          ent_wd = '{valid: 1'b1, writable: 1'b0, priv: ent_r.priv, pfn: ent_r.pfn};
        end
        v_nxt = v_r + 1'b1;
        if (fk_last) begin
          used_nxt[child_r]    = 1'b1;
          slotpid_nxt[child_r] = pid_r;
          cur_nxt              = child_r;
        end
      end
      cpfm_pkg::FS_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'b0, frame_r, status_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpfm_pkg::FS_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      used_r      <= SLOTS'(1);
      out_valid_r <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        slotpid_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      slotpid_r   <= slotpid_nxt;
    end
    op_r       <= op_nxt;
    vpn_r      <= vpn_nxt;
    ro_r       <= ro_nxt;
    pid_r      <= pid_nxt;
    ent_r      <= ent_nxt;
    cnt_r      <= cnt_nxt;
    status_r   <= status_nxt;
    frame_r    <= frame_nxt;
    v_r        <= v_nxt;
    child_r    <= child_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == cpfm_pkg::FS_DISPATCH))
    else $error("accepted command was not dispatched");

  a_current_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r[cur_r])
    else $error("current slot is not in use");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpfm_pkg::FS_IDLE) |-> (!ent_we && !sreq.wr_en))
    else $error("memory write while idle");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == cpfm_pkg::FS_DONE) && (!out_valid_r || out_tready)) |=> out_valid_r)
    else $error("finished command produced no result");
`endif

endmodule
